[rtl/fnc_pkg.sv]
// ----------------------------------------------------------------------------
// fnc_pkg: shared constants and types for the frequency to note quantizer
// Formats, the per-cell payload and the leading-one search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fnc_pkg;

  localparam int unsigned LogFracBits = 20;
  localparam int unsigned FreqW       = 32;
  localparam int unsigned MantW       = 32;
  localparam int unsigned PosW        = 5;
  localparam int unsigned LogW        = PosW + LogFracBits;
  localparam int unsigned VW          = LogFracBits + 12;  // signed note value
  localparam int unsigned PW          = VW + 14;           // scaled deviation
  localparam int unsigned RefW        = 17;
  localparam int unsigned NoteW       = 9;
  localparam int unsigned CentsW      = 14;
  localparam int unsigned PcW         = 4;
  localparam int unsigned OctW        = 6;

  localparam int A4Note     = 69;
  localparam int NoteMin    = -256;
  localparam int NoteMax    = 255;
  localparam int CentsLimit = 5000;
  localparam int CentsScale = 10000;
  localparam int RefReset   = 112640;
  localparam int DefPc      = 9;
  localparam int DefOct     = 4;

  // q = floor(n/12) for n <= 256
  localparam int RecipMul   = 171;
  localparam int RecipShift = 11;

  // accept edge to the edge that samples the strobe
  localparam int unsigned PipeDepth = LogFracBits + 5;

  typedef struct packed {
    logic                   inv;
    logic [PosW-1:0]        pf;
    logic [PosW-1:0]        pr;
    logic [MantW-1:0]       mf;
    logic [MantW-1:0]       mr;
    logic [LogFracBits-1:0] ff;
    logic [LogFracBits-1:0] fr;
  } cell_t;

  function automatic logic [PosW-1:0] msb_pos(input logic [FreqW-1:0] x);
    logic [PosW-1:0] p;
    p = '0;
    for (int i = 0; i < FreqW; i++) begin
      if (x[i]) p = PosW'(i);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/frequency_to_note_cents.sv]
// ----------------------------------------------------------------------------
// frequency_to_note_cents: tuner quantizer
// Measured frequency (Q24.8 Hz) to nearest MIDI note, deviation in 1/100
// cent, pitch class and octave.
//
// Usage:
//   Input beat: frequency_i taken at a clock edge with start high and busy low.
//   busy is always low: the pipeline takes one beat every cycle.
//   Result beat: done_o high for one cycle with note_o, cents_hundredths_o,
//   pitch_class_o, octave_o and invalid_o; the receiver takes it that cycle.
//   Pipeline: a beat is registered in the normalizer, 20 log2 cells and four
//   back-end stages in turn; done_o rises from the last of these.
//   Throughput: one beat per cycle; each log2 cell squares both mantissas
//   with its own multipliers, so the cell row sets the pace.
//   reference_a4 is written with reference_a4_we_i; write only while no beat
//   is in flight.
//   Reset: pipeline empties, reference returns to 440 Hz.
//   Zero frequency or zero reference gives note 69, cents 0, invalid set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frequency_to_note_cents (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [fnc_pkg::FreqW-1:0]           frequency_i,
  input  wire logic                                reference_a4_we_i,
  input  wire logic [fnc_pkg::RefW-1:0]            reference_a4_i,
  output logic                                     done_o,
  output logic signed [fnc_pkg::NoteW-1:0]         note_o,
  output logic signed [fnc_pkg::CentsW-1:0]        cents_hundredths_o,
  output logic        [fnc_pkg::PcW-1:0]           pitch_class_o,
  output logic signed [fnc_pkg::OctW-1:0]          octave_o,
  output logic                                     invalid_o
);

  localparam int unsigned N = fnc_pkg::LogFracBits;

  logic [fnc_pkg::RefW-1:0] ref_q;
  logic                     acc;
  logic [N:0]               vld;
  fnc_pkg::cell_t           chain [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= fnc_pkg::RefW'(fnc_pkg::RefReset);
    end else if (reference_a4_we_i) begin
      ref_q <= reference_a4_i;
    end
  end

  assign busy = 1'b0;
  assign acc  = start && !busy;

  fnc_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (acc),
    .freq_i (frequency_i),
    .ref_i  (ref_q),
    .vld_o  (vld[0]),
    .cell_o (chain[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    fnc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[g]),
      .cell_i (chain[g]),
      .vld_o  (vld[g+1]),
      .cell_o (chain[g+1])
    );
  end

  fnc_post u_post (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .vld_i              (vld[N]),
    .cell_i             (chain[N]),
    .done_o             (done_o),
    .note_o             (note_o),
    .cents_hundredths_o (cents_hundredths_o),
    .pitch_class_o      (pitch_class_o),
    .octave_o           (octave_o),
    .invalid_o          (invalid_o)
  );

endmodule

`default_nettype wire

[rtl/fnc_norm.sv]
// ----------------------------------------------------------------------------
// fnc_norm: input normalizer
// Finds the leading one of frequency and reference, left-aligns both mantissas.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fnc_norm (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         vld_i,
  input  wire logic [fnc_pkg::FreqW-1:0]    freq_i,
  input  wire logic [fnc_pkg::RefW-1:0]     ref_i,
  output logic                              vld_o,
  output fnc_pkg::cell_t                    cell_o
);

  logic                         vld_q;
  fnc_pkg::cell_t               cell_d, cell_q;
  logic [fnc_pkg::FreqW-1:0]    ref_w;

  always_comb begin
    ref_w       = fnc_pkg::FreqW'(ref_i);
    cell_d.inv  = (freq_i == '0) || (ref_i == '0);
    cell_d.pf   = fnc_pkg::msb_pos(freq_i);
    cell_d.pr   = fnc_pkg::msb_pos(ref_w);
    cell_d.mf   = fnc_pkg::MantW'(freq_i << (fnc_pkg::PosW'(fnc_pkg::FreqW - 1) - cell_d.pf));
    cell_d.mr   = fnc_pkg::MantW'(ref_w << (fnc_pkg::PosW'(fnc_pkg::FreqW - 1) - cell_d.pr));
    cell_d.ff   = '0;
    cell_d.fr   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

`default_nettype wire

[rtl/fnc_cell.sv]
// ----------------------------------------------------------------------------
// fnc_cell: one log2 fraction bit
// Squares both mantissas, shifts in one fraction bit each, passes on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fnc_cell (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       vld_i,
  input  fnc_pkg::cell_t  cell_i,
  output logic            vld_o,
  output fnc_pkg::cell_t  cell_o
);

  localparam int unsigned MW = fnc_pkg::MantW;

  logic                 vld_q;
  fnc_pkg::cell_t       cell_d, cell_q;
  logic [2*MW-1:0]      sq_f, sq_r;
  logic [MW:0]          s_f, s_r;

  always_comb begin
    sq_f   = {{MW{1'b0}}, cell_i.mf} * {{MW{1'b0}}, cell_i.mf};
    sq_r   = {{MW{1'b0}}, cell_i.mr} * {{MW{1'b0}}, cell_i.mr};
    s_f    = sq_f[2*MW-1:MW-1];
    s_r    = sq_r[2*MW-1:MW-1];
    cell_d = cell_i;
    // square >= 2.0: bit is one, halve
    cell_d.ff = {cell_i.ff[fnc_pkg::LogFracBits-2:0], s_f[MW]};
    cell_d.fr = {cell_i.fr[fnc_pkg::LogFracBits-2:0], s_r[MW]};
    cell_d.mf = s_f[MW] ? s_f[MW:1] : s_f[MW-1:0];
    cell_d.mr = s_r[MW] ? s_r[MW:1] : s_r[MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

`default_nettype wire

[rtl/fnc_post.sv]
// ----------------------------------------------------------------------------
// fnc_post: note and deviation back end
// Scales the log difference, rounds to a note, scales the remainder to
// hundredths of a cent, splits the note into pitch class and octave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fnc_post (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                vld_i,
  input  fnc_pkg::cell_t                           cell_i,
  output logic                                     done_o,
  output logic signed [fnc_pkg::NoteW-1:0]         note_o,
  output logic signed [fnc_pkg::CentsW-1:0]        cents_hundredths_o,
  output logic        [fnc_pkg::PcW-1:0]           pitch_class_o,
  output logic signed [fnc_pkg::OctW-1:0]          octave_o,
  output logic                                     invalid_o
);

  localparam int unsigned F  = fnc_pkg::LogFracBits;
  localparam int unsigned VW = fnc_pkg::VW;
  localparam int unsigned PW = fnc_pkg::PW;
  localparam int unsigned LW = fnc_pkg::LogW;
  localparam int unsigned NW = fnc_pkg::NoteW;
  localparam int unsigned CW = fnc_pkg::CentsW;

  localparam logic [VW-1:0]        HalfV   = VW'(1) << (F - 1);
  localparam logic [PW-1:0]        HalfP   = PW'(1) << (F - 1);
  localparam logic signed [VW-1:0] A4V     = VW'(fnc_pkg::A4Note) <<< F;
  localparam logic signed [VW-1:0] NoteLoV = VW'(fnc_pkg::NoteMin);
  localparam logic signed [VW-1:0] NoteHiV = VW'(fnc_pkg::NoteMax);
  localparam logic signed [PW-1:0] CentHiP = PW'(fnc_pkg::CentsLimit);
  localparam logic signed [PW-1:0] CentLoP = -PW'(fnc_pkg::CentsLimit);

  // stage 1: v = 12 * (Lf - La) + 69
  logic                 vld1_q, inv1_q;
  logic signed [VW-1:0] v1_d, v1_q;
  logic signed [LW:0]   diff;
  logic signed [VW-1:0] dx;

  always_comb begin
    diff = $signed({1'b0, cell_i.pf, cell_i.ff}) - $signed({1'b0, cell_i.pr, cell_i.fr});
    dx   = VW'(diff);
    v1_d = (dx <<< 3) + (dx <<< 2) + A4V;
  end

  // stage 2: round to note, saturate
  logic                 vld2_q, inv2_q;
  logic signed [VW-1:0] v2_q;
  logic [VW-1:0]        mag2, q2;
  logic signed [VW-1:0] nr2;
  logic signed [NW-1:0] note2_d, note2_q;

  always_comb begin
    mag2 = v1_q[VW-1] ? VW'(-v1_q) : VW'(v1_q);
    q2   = (mag2 + HalfV) >> F;
    nr2  = v1_q[VW-1] ? -$signed(q2) : $signed(q2);
    if (inv1_q) begin
      note2_d = NW'(fnc_pkg::A4Note);
    end else if (nr2 < NoteLoV) begin
      note2_d = NW'(fnc_pkg::NoteMin);
    end else if (nr2 > NoteHiV) begin
      note2_d = NW'(fnc_pkg::NoteMax);
    end else begin
      note2_d = NW'(nr2);
    end
  end

  // stage 3: remainder times 10000
  logic                 vld3_q, inv3_q;
  logic signed [NW-1:0] note3_q;
  logic signed [VW-1:0] r3;
  logic signed [PW-1:0] r3x, prod3_d, prod3_q;

  always_comb begin
    r3      = v2_q - (VW'(note2_q) <<< F);
    r3x     = PW'(r3);
    // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
    prod3_d = (r3x <<< 13) + (r3x <<< 10) + (r3x <<< 9) + (r3x <<< 8) + (r3x <<< 4);
  end

  // stage 4: round deviation, pitch class and octave
  logic [PW-1:0]        mag4, q4;
  logic signed [PW-1:0] c4;
  logic signed [CW-1:0] cents_d;
  logic [NW-1:0]        nmag;
  logic [NW+7:0]        nprod;
  logic [4:0]           nq;
  logic [fnc_pkg::PcW-1:0] rem, pc_d;
  logic signed [fnc_pkg::OctW-1:0] oct_d;

  always_comb begin
    mag4 = prod3_q[PW-1] ? PW'(-prod3_q) : PW'(prod3_q);
    q4   = (mag4 + HalfP) >> F;
    c4   = prod3_q[PW-1] ? -$signed(q4) : $signed(q4);
    if (inv3_q) begin
      cents_d = '0;
    end else if (c4 > CentHiP) begin
      cents_d = CW'(fnc_pkg::CentsLimit);
    end else if (c4 < CentLoP) begin
      cents_d = -CW'(fnc_pkg::CentsLimit);
    end else begin
      cents_d = CW'(c4);
    end

    nmag  = note3_q[NW-1] ? NW'(-note3_q) : NW'(note3_q);
    nprod = (NW+8)'(nmag) * (NW+8)'(fnc_pkg::RecipMul);
    nq    = 5'(nprod >> fnc_pkg::RecipShift);
    rem   = fnc_pkg::PcW'(nmag - NW'(nq) * NW'(12));
    // C remainder follows the dividend's sign; fold into 0..11
    if (note3_q[NW-1] && (rem != '0)) begin
      pc_d = fnc_pkg::PcW'(12) - rem;
    end else begin
      pc_d = rem;
    end
    oct_d = (note3_q[NW-1] ? -$signed(fnc_pkg::OctW'(nq)) : $signed(fnc_pkg::OctW'(nq)))
            - fnc_pkg::OctW'(1);
  end

  logic                          done_q, inv4_q;
  logic signed [NW-1:0]          note4_q;
  logic signed [CW-1:0]          cents4_q;
  logic [fnc_pkg::PcW-1:0]       pc4_q;
  logic signed [fnc_pkg::OctW-1:0] oct4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      done_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    inv1_q   <= cell_i.inv;
    v1_q     <= v1_d;
    inv2_q   <= inv1_q;
    v2_q     <= v1_q;
    note2_q  <= note2_d;
    inv3_q   <= inv2_q;
    note3_q  <= note2_q;
    prod3_q  <= prod3_d;
    inv4_q   <= inv3_q;
    note4_q  <= note3_q;
    cents4_q <= cents_d;
    pc4_q    <= pc_d;
    oct4_q   <= oct_d;
  end

  assign done_o             = done_q;
  assign note_o             = note4_q;
  assign cents_hundredths_o = cents4_q;
  assign pitch_class_o      = pc4_q;
  assign octave_o           = oct4_q;
  assign invalid_o          = inv4_q;

endmodule

`default_nettype wire

[rtl/fnc_chk.sv]
// ----------------------------------------------------------------------------
// fnc_chk: port-level checks for the quantizer
// Fixed latency, default answer on invalid, output field ranges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fnc_chk (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire logic                                done_o,
  input  wire logic signed [fnc_pkg::NoteW-1:0]    note_o,
  input  wire logic signed [fnc_pkg::CentsW-1:0]   cents_hundredths_o,
  input  wire logic        [fnc_pkg::PcW-1:0]      pitch_class_o,
  input  wire logic signed [fnc_pkg::OctW-1:0]     octave_o,
  input  wire logic                                invalid_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(fnc_pkg::PipeDepth) done_o)
    else $error("result beat missing after fixed latency");

  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, fnc_pkg::PipeDepth))
    else $error("result beat without input beat");

  a_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && invalid_o) |-> (note_o == fnc_pkg::NoteW'(fnc_pkg::A4Note))
      && (cents_hundredths_o == '0)
      && (pitch_class_o == fnc_pkg::PcW'(fnc_pkg::DefPc))
      && (octave_o == fnc_pkg::OctW'(fnc_pkg::DefOct)))
    else $error("invalid beat without default answer");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pitch_class_o < fnc_pkg::PcW'(12))
      && (cents_hundredths_o <= fnc_pkg::CentsW'(fnc_pkg::CentsLimit))
      && (cents_hundredths_o >= -fnc_pkg::CentsW'(fnc_pkg::CentsLimit)))
    else $error("result field out of range");

endmodule

bind frequency_to_note_cents fnc_chk u_fnc_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .done_o             (done_o),
  .note_o             (note_o),
  .cents_hundredths_o (cents_hundredths_o),
  .pitch_class_o      (pitch_class_o),
  .octave_o           (octave_o),
  .invalid_o          (invalid_o)
);

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: frequency to note quantizer
// Directed table then random frequencies; every result beat is checked
// against a local fixed-point log2 model, over several A4 references.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FracBits = fnc_pkg::LogFracBits;
  localparam int          WatchLimit = 20000;
  localparam int          DrainCycles = 40;

  typedef struct packed {
    logic signed [8:0]  note;
    logic signed [13:0] cents;
    logic [3:0]         pc;
    logic signed [5:0]  oct;
    logic               inv;
  } note_res_t;

  typedef struct {
    logic [31:0] freq;
    logic        has_exp;
    note_res_t   exp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] frequency_i = '0;
  logic reference_a4_we_i = 1'b0;
  logic [16:0] reference_a4_i = '0;
  logic done_o;
  logic signed [8:0] note_o;
  logic signed [13:0] cents_hundredths_o;
  logic [3:0] pitch_class_o;
  logic signed [5:0] octave_o;
  logic invalid_o;

  logic [16:0] a4_ref;
  note_res_t   pending_notes[$];
  int          errors = 0;
  int          idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  frequency_to_note_cents dut (
    .clk_i, .rst_ni, .start, .busy, .frequency_i,
    .reference_a4_we_i, .reference_a4_i, .done_o, .note_o,
    .cents_hundredths_o, .pitch_class_o, .octave_o, .invalid_o
  );

  function automatic longint unsigned log2_fixed(input logic [31:0] x);
    int unsigned p;
    logic [63:0] m;
    logic [63:0] frac;
    p = 31;
    frac = '0;
    while (p > 0 && !x[p]) p--;
    m = 64'(x) << (31 - p);
    for (int i = 0; i < FracBits; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (longint'(p) << FracBits) | frac;
  endfunction

  function automatic longint round_half_away(input longint v);
    longint half;
    half = longint'(1) << (FracBits - 1);
    if (v < 0) return -((-v + half) >>> FracBits);
    return (v + half) >>> FracBits;
  endfunction

  function automatic note_res_t quantize_freq(input logic [31:0] f);
    note_res_t r;
    longint nt, cents, v, rem, one;
    nt = fnc_pkg::A4Note;
    cents = 0;
    r.inv = 1'b1;
    one = longint'(1) << FracBits;
    if (f != 0 && a4_ref != 0) begin
      v = 12 * (longint'(log2_fixed(f)) - longint'(log2_fixed(32'(a4_ref))))
          + fnc_pkg::A4Note * one;
      nt = round_half_away(v);
      if (nt < fnc_pkg::NoteMin) nt = fnc_pkg::NoteMin;
      if (nt > fnc_pkg::NoteMax) nt = fnc_pkg::NoteMax;
      rem = v - nt * one;
      cents = round_half_away(rem * fnc_pkg::CentsScale);
      if (cents > fnc_pkg::CentsLimit) cents = fnc_pkg::CentsLimit;
      if (cents < -fnc_pkg::CentsLimit) cents = -fnc_pkg::CentsLimit;
      r.inv = 1'b0;
    end
    r.note = 9'(nt);
    r.cents = 14'(cents);
    r.pc = 4'(((nt % 12) + 12) % 12);
    r.oct = 6'(nt / 12 - 1);
    return r;
  endfunction

  // result side: one beat per strobe, no backpressure
  always @(posedge clk_i) begin
    note_res_t e;
    if (done_o) begin
      if (pending_notes.size() == 0) begin
        $display("%0t: unexpected beat note=%0d", $time, note_o);
        errors++;
      end else begin
        e = pending_notes.pop_front();
        if (note_o !== e.note || cents_hundredths_o !== e.cents ||
            pitch_class_o !== e.pc || octave_o !== e.oct || invalid_o !== e.inv) begin
          $display("%0t: mismatch exp n=%0d c=%0d pc=%0d o=%0d i=%0b",
                   $time, e.note, e.cents, e.pc, e.oct, e.inv);
          $display("%0t:          got n=%0d c=%0d pc=%0d o=%0d i=%0b",
                   $time, note_o, cents_hundredths_o, pitch_class_o, octave_o,
                   invalid_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_freq(input logic [31:0] f, input logic has_exp, input note_res_t ex);
    note_res_t p;
    start <= 1'b1;
    frequency_i <= f;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    p = quantize_freq(f);
    if (has_exp && p != ex) begin
      $display("%0t: table row f=%0h exp n=%0d c=%0d pred n=%0d c=%0d",
               $time, f, ex.note, ex.cents, p.note, p.cents);
      errors++;
    end
    pending_notes.insert(pending_notes.size(), p);
    // random gap, mostly short
    if ($urandom_range(0, 2) == 0) begin
      int g;
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_set(input logic [16:0] val);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_notes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    reference_a4_we_i <= 1'b1;
    reference_a4_i <= val;
    @(posedge clk_i);
    reference_a4_we_i <= 1'b0;
    a4_ref = val;
    @(posedge clk_i);
  endtask

  task automatic random_burst(input int n);
    logic [31:0] f;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: f = $urandom();
        1: f = $urandom_range(2560, 5120000);    // 10 Hz .. 20 kHz
        2: f = $urandom() >> $urandom_range(0, 31);
        default: f = (32'd1 << $urandom_range(0, 31)) | $urandom_range(0, 1);
      endcase
      send_freq(f, 1'b0, '{default: '0});
    end
  endtask

  stim_row_t rows[$];
  logic [16:0] refs[6] = '{17'd102400, 17'd122880, 17'd0, 17'd1, 17'h1FFFF, 17'd112640};

  task automatic add_row(input logic [31:0] f, input logic has_exp, input note_res_t ex);
    stim_row_t row;
    row.freq = f;
    row.has_exp = has_exp;
    row.exp = ex;
    rows.insert(rows.size(), row);
  endtask

  initial begin
    note_res_t dflt, a4;
    dflt = '{note: 9'sd69, cents: 14'sd0, pc: 4'd9, oct: 6'sd4, inv: 1'b1};
    a4 = '{note: 9'sd69, cents: 14'sd0, pc: 4'd9, oct: 6'sd4, inv: 1'b0};
    a4_ref = 17'd112640;
    add_row(32'd0, 1'b1, dflt);
    add_row(32'd112640, 1'b1, a4);
    add_row(32'd225280, 1'b1, '{9'sd81, 14'sd0, 4'd9, 6'sd5, 1'b0});
    add_row(32'd56320, 1'b1, '{9'sd57, 14'sd0, 4'd9, 6'sd3, 1'b0});
    add_row(32'hFFFFFFFF, 1'b0, dflt);
    add_row(32'd1, 1'b0, dflt);
    add_row(32'd2, 1'b0, dflt);
    add_row(32'h80000000, 1'b0, dflt);
    add_row(32'd66976, 1'b0, dflt);
    add_row(32'd115950, 1'b0, dflt);
    add_row(32'd109400, 1'b0, dflt);
    add_row(32'd5555, 1'b0, dflt);
    add_row(32'h55555555, 1'b0, dflt);
    add_row(32'hAAAAAAAA, 1'b0, dflt);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_freq(rows[i].freq, rows[i].has_exp, rows[i].exp);
    random_burst(300);
    foreach (refs[k]) begin
      drain_and_set(refs[k]);
      if (refs[k] == 17'd0) send_freq(32'd1000, 1'b1, dflt);
      send_freq(32'd0, 1'b1, dflt);
      random_burst(refs[k] < 17'd2 || refs[k] == 17'h1FFFF ? 60 : 160);
    end
    drain_and_set(17'($urandom_range(102400, 122880)));
    random_burst(100);

    start <= 1'b0;
    @(posedge clk_i);
    while (pending_notes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
